// File: sv/nir_pkg.sv
// shared types and constants for the nec ir frame decoder
package nir_pkg;

	localparam int unsigned TICK_W     = 15;
	localparam int unsigned WORD_W     = 16;
	localparam int unsigned SHIFT_W    = 2 * WORD_W;
	localparam int unsigned POS_W      = $clog2(SHIFT_W);
	localparam int unsigned COUNT_W    = 6;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned NUM_REGS   = 8;
	localparam int unsigned REG_IDX_W  = $clog2(NUM_REGS);
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_W-1:0] FRAME_SYMBOLS  = COUNT_W'(34);
	localparam logic [COUNT_W-1:0] REPEAT_SYMBOLS = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] COUNT_CAP      = COUNT_W'(35);
	localparam logic [COUNT_W-1:0] LAST_DATA_IDX  = COUNT_W'(SHIFT_W);

	localparam logic [STATUS_W-1:0] ST_FRAME_OK   = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_REPEAT_OK  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_FRAME_BAD  = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] ST_REPEAT_BAD = STATUS_W'(3);
	localparam logic [STATUS_W-1:0] ST_WRONG_LEN  = STATUS_W'(4);

	localparam logic [REG_IDX_W-1:0] REG_MARGIN       = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_LEADER_MARK  = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_LEADER_SPACE = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_BIT_MARK     = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_ZERO_SPACE   = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE    = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_MARK  = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_REPEAT_SPACE = REG_IDX_W'(7);

	localparam logic [TICK_W-1:0] RST_MARGIN       = TICK_W'(200);
	localparam logic [TICK_W-1:0] RST_LEADER_MARK  = TICK_W'(9000);
	localparam logic [TICK_W-1:0] RST_LEADER_SPACE = TICK_W'(4500);
	localparam logic [TICK_W-1:0] RST_BIT_MARK     = TICK_W'(560);
	localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = TICK_W'(560);
	localparam logic [TICK_W-1:0] RST_ONE_SPACE    = TICK_W'(1690);
	localparam logic [TICK_W-1:0] RST_REPEAT_MARK  = TICK_W'(9000);
	localparam logic [TICK_W-1:0] RST_REPEAT_SPACE = TICK_W'(2250);

	typedef struct packed {
		logic [TICK_W-1:0] mark_ticks;
		logic [TICK_W-1:0] space_ticks;
		logic              end_of_frame;
	} sym_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   address_word;
		logic [WORD_W-1:0]   command_word;
	} res_t;

	typedef struct packed {
		logic leader_ok;
		logic repeat_ok;
		logic zero_ok;
		logic one_ok;
		logic end_of_frame;
	} cls_t;

endpackage

// File: sv/nir_front.sv
// front end: timing registers and window classification of each symbol
module nir_front (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_write,
	input  logic [nir_pkg::REG_IDX_W-1:0]            cfg_index,
	input  logic [nir_pkg::TICK_W-1:0]               cfg_data,
	input  nir_pkg::sym_t                            sym,
	output nir_pkg::cls_t                            cls
);

	logic [nir_pkg::TICK_W-1:0] margin_q;
	logic [nir_pkg::TICK_W-1:0] leader_mark_q;
	logic [nir_pkg::TICK_W-1:0] leader_space_q;
	logic [nir_pkg::TICK_W-1:0] bit_mark_q;
	logic [nir_pkg::TICK_W-1:0] zero_space_q;
	logic [nir_pkg::TICK_W-1:0] one_space_q;
	logic [nir_pkg::TICK_W-1:0] repeat_mark_q;
	logic [nir_pkg::TICK_W-1:0] repeat_space_q;

	function automatic logic in_window(
		input logic [nir_pkg::TICK_W-1:0] d,
		input logic [nir_pkg::TICK_W-1:0] e,
		input logic [nir_pkg::TICK_W-1:0] m
	);
		logic [nir_pkg::TICK_W-1:0] lo;
		logic [nir_pkg::TICK_W:0]   hi;
		lo = (e > m) ? (e - m) : '0;
		hi = {1'b0, e} + {1'b0, m};
		return (d > lo) && ({1'b0, d} < hi);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q       <= nir_pkg::RST_MARGIN;
			leader_mark_q  <= nir_pkg::RST_LEADER_MARK;
			leader_space_q <= nir_pkg::RST_LEADER_SPACE;
			bit_mark_q     <= nir_pkg::RST_BIT_MARK;
			zero_space_q   <= nir_pkg::RST_ZERO_SPACE;
			one_space_q    <= nir_pkg::RST_ONE_SPACE;
			repeat_mark_q  <= nir_pkg::RST_REPEAT_MARK;
			repeat_space_q <= nir_pkg::RST_REPEAT_SPACE;
		end else if (cfg_write) begin
			case (cfg_index)
				nir_pkg::REG_MARGIN:       margin_q       <= cfg_data;
				nir_pkg::REG_LEADER_MARK:  leader_mark_q  <= cfg_data;
				nir_pkg::REG_LEADER_SPACE: leader_space_q <= cfg_data;
				nir_pkg::REG_BIT_MARK:     bit_mark_q     <= cfg_data;
				nir_pkg::REG_ZERO_SPACE:   zero_space_q   <= cfg_data;
				nir_pkg::REG_ONE_SPACE:    one_space_q    <= cfg_data;
				nir_pkg::REG_REPEAT_MARK:  repeat_mark_q  <= cfg_data;
				nir_pkg::REG_REPEAT_SPACE: repeat_space_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic bit_mark_ok;

	always_comb begin
		bit_mark_ok      = in_window(sym.mark_ticks, bit_mark_q, margin_q);
		cls.leader_ok    = in_window(sym.mark_ticks, leader_mark_q, margin_q)
			&& in_window(sym.space_ticks, leader_space_q, margin_q);
		cls.repeat_ok    = in_window(sym.mark_ticks, repeat_mark_q, margin_q)
			&& in_window(sym.space_ticks, repeat_space_q, margin_q);
		cls.zero_ok      = bit_mark_ok && in_window(sym.space_ticks, zero_space_q, margin_q);
		cls.one_ok       = bit_mark_ok && in_window(sym.space_ticks, one_space_q, margin_q);
		cls.end_of_frame = sym.end_of_frame;
	end

endmodule

// File: sv/nir_queue.sv
// short queue of classified symbols between front and back
module nir_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  nir_pkg::cls_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output nir_pkg::cls_t rd_data
);

	nir_pkg::cls_t                     mem_q [nir_pkg::QUEUE_DEPTH];
	logic [nir_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [nir_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [nir_pkg::QCNT_W-1:0]        count_q;

	localparam logic [nir_pkg::QPTR_W-1:0] LAST_PTR = nir_pkg::QPTR_W'(nir_pkg::QUEUE_DEPTH - 1);
	localparam logic [nir_pkg::QCNT_W-1:0] DEPTH_CNT = nir_pkg::QCNT_W'(nir_pkg::QUEUE_DEPTH);

	assign full     = (count_q == DEPTH_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/nir_back.sv
// back end: symbol counting, bit assembly, frame verdict and result register
module nir_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  nir_pkg::cls_t q_data,
	output logic          q_take,
	output logic          res_valid,
	input  logic          res_ready,
	output nir_pkg::res_t res
);

	logic [nir_pkg::COUNT_W-1:0] count_q;
	logic [nir_pkg::SHIFT_W-1:0] shift_q;
	logic                        frame_good_q;
	logic                        repeat_good_q;
	logic [nir_pkg::WORD_W-1:0]  last_addr_q;
	logic [nir_pkg::WORD_W-1:0]  last_cmd_q;
	logic                        res_valid_q;
	nir_pkg::res_t               res_q;

	logic [nir_pkg::COUNT_W-1:0] count_n;
	logic [nir_pkg::SHIFT_W-1:0] shift_n;
	logic                        frame_good_n;
	logic                        repeat_good_n;
	logic [nir_pkg::COUNT_W-1:0] pos_full;
	logic [nir_pkg::POS_W-1:0]   pos;
	logic [nir_pkg::WORD_W-1:0]  addr_n;
	logic [nir_pkg::WORD_W-1:0]  cmd_n;
	logic [nir_pkg::STATUS_W-1:0] status_n;

	assign q_take    = q_valid && (!q_data.end_of_frame || !res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		pos_full      = count_q - 1'b1;
		pos           = pos_full[nir_pkg::POS_W-1:0];
		shift_n       = shift_q;
		frame_good_n  = frame_good_q;
		repeat_good_n = repeat_good_q;
		if (count_q == '0) begin
			frame_good_n  = q_data.leader_ok;
			repeat_good_n = q_data.repeat_ok;
		end else if (count_q <= nir_pkg::LAST_DATA_IDX) begin
			if (q_data.zero_ok) begin
				shift_n = shift_q;
			end else if (q_data.one_ok) begin
				shift_n = shift_q | (nir_pkg::SHIFT_W'(1) << pos);
			end else begin
				frame_good_n = 1'b0;
			end
		end
		count_n  = (count_q < nir_pkg::COUNT_CAP) ? count_q + 1'b1 : count_q;
		addr_n   = last_addr_q;
		cmd_n    = last_cmd_q;
		status_n = nir_pkg::ST_WRONG_LEN;
		if (count_n == nir_pkg::FRAME_SYMBOLS) begin
			if (frame_good_n) begin
				addr_n   = shift_n[nir_pkg::WORD_W-1:0];
				cmd_n    = shift_n[nir_pkg::SHIFT_W-1:nir_pkg::WORD_W];
				status_n = nir_pkg::ST_FRAME_OK;
			end else begin
				status_n = nir_pkg::ST_FRAME_BAD;
			end
		end else if (count_n == nir_pkg::REPEAT_SYMBOLS) begin
			status_n = repeat_good_n ? nir_pkg::ST_REPEAT_OK : nir_pkg::ST_REPEAT_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			shift_q       <= '0;
			frame_good_q  <= 1'b1;
			repeat_good_q <= 1'b0;
			last_addr_q   <= '0;
			last_cmd_q    <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (q_take && q_data.end_of_frame) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (q_take) begin
				if (q_data.end_of_frame) begin
					count_q       <= '0;
					shift_q       <= '0;
					frame_good_q  <= 1'b1;
					repeat_good_q <= 1'b0;
					last_addr_q   <= addr_n;
					last_cmd_q    <= cmd_n;
				end else begin
					count_q       <= count_n;
					shift_q       <= shift_n;
					frame_good_q  <= frame_good_n;
					repeat_good_q <= repeat_good_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_take && q_data.end_of_frame) begin
			res_q.status       <= status_n;
			res_q.address_word <= addr_n;
			res_q.command_word <= cmd_n;
		end
	end

endmodule

// File: sv/nir_top_unused_placeholder.sv
// classified-symbol write path: gates front-end output into the queue
module nir_feed (
	input  logic          sym_valid,
	input  logic          q_full,
	input  nir_pkg::cls_t cls,
	output logic          sym_ready,
	output logic          wr_en,
	output nir_pkg::cls_t wr_data
);

	always_comb begin
		sym_ready = !q_full;
		wr_en     = sym_valid && !q_full;
		wr_data   = cls;
	end

endmodule

// File: sv/nec_ir_frame_decoder_unit.sv
// nec ir frame decoder top level
// Takes one IR symbol (mark ticks, space ticks, end-of-frame flag) per transaction and gives
// one status transaction per frame: a 34-symbol frame is checked as leader plus 32 data bits
// (LSB first, address word then command word, stored when good), a 2-symbol frame as a repeat
// code, anything else reports wrong length; every result carries the stored words. A symbol
// is taken every cycle while the queue is not full: the front end classifies it against all
// timing windows in the cycle it arrives and writes it into a two-entry queue, the back end
// retires one queued symbol per cycle unless stalled and loads the output register when it
// takes the last symbol of a frame, so a result is valid the cycle after. A result still held
// at the next frame end stalls the back end and the queue then fills. The user must write timing
// registers through cfg_write/cfg_index/cfg_data only while no frame is in flight; not enforced.
module nec_ir_frame_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [nir_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [nir_pkg::TICK_W-1:0]    cfg_data,
	input  logic                          sym_valid,
	output logic                          sym_ready,
	input  nir_pkg::sym_t                 sym,
	output logic                          res_valid,
	input  logic                          res_ready,
	output nir_pkg::res_t                 res
);

	nir_pkg::cls_t cls;
	nir_pkg::cls_t wr_data;
	nir_pkg::cls_t rd_data;
	logic          wr_en;
	logic          q_full;
	logic          rd_valid;
	logic          rd_en;

	nir_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sym       (sym),
		.cls       (cls)
	);

	nir_feed u_feed (
		.sym_valid (sym_valid),
		.q_full    (q_full),
		.cls       (cls),
		.sym_ready (sym_ready),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	nir_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.full     (q_full),
		.rd_en    (rd_en),
		.rd_valid (rd_valid),
		.rd_data  (rd_data)
	);

	nir_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (rd_valid),
		.q_data    (rd_data),
		.q_take    (rd_en),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
